[rtl/core/spsm_pkg.sv]
// ----------------------------------------------------------------------------
// spsm_pkg
// Types and constants shared by the slotted page slot manager.
// ----------------------------------------------------------------------------
package spsm_pkg;

    localparam int PAGE_BYTES   = 4096;
    localparam int HEADER_BYTES = 20;
    localparam int SLOT_BYTES   = 12;
    localparam int SLOT_CAP     = (PAGE_BYTES - HEADER_BYTES) / SLOT_BYTES;
    localparam int SLOT_W       = $clog2(SLOT_CAP);

    localparam int BYTE_W = 13;     // offsets, sizes and lengths
    localparam int PAGE_W = 31;
    localparam int IDX_W  = 10;
    localparam int IN_W   = 32;
    localparam int OUT_W  = 88;

    typedef enum logic [2:0] {
        ACT_INIT   = 3'd0,
        ACT_INSERT = 3'd1,
        ACT_READ   = 3'd2,
        ACT_MARK   = 3'd3,
        ACT_UNMARK = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        STAT_OK          = 3'd0,
        STAT_NO_SPACE    = 3'd1,
        STAT_OUT_OF_RANGE = 3'd2,
        STAT_INVALID     = 3'd3,
        STAT_DELETED     = 3'd4,
        STAT_NOT_DELETED = 3'd5
    } status_t;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    // last field in the lowest bits
    typedef struct packed {
        logic [IN_W-BYTE_W-IDX_W-4:0] pad;
        logic [IDX_W-1:0]             slot_number;
        logic [BYTE_W-1:0]            tuple_length;
        logic [2:0]                   action;
    } request_t;

    typedef struct packed {
        logic [OUT_W-3-PAGE_W-9-3*BYTE_W-1:0] pad;
        logic [BYTE_W-1:0]                    free_bytes;
        logic [BYTE_W-1:0]                    tuple_size;
        logic [BYTE_W-1:0]                    tuple_offset;
        logic [8:0]                           record_slot;
        logic [PAGE_W-1:0]                    record_page;
        logic [2:0]                           status;
    } result_t;

    typedef struct packed {
        logic              deleted;
        logic [BYTE_W-1:0] size;
        logic [BYTE_W-1:0] offset;
    } slot_entry_t;

endpackage

[rtl/core/spsm_ram.sv]
// ----------------------------------------------------------------------------
// spsm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module spsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/core/slotted_page_slot_manager_top.sv]
// ----------------------------------------------------------------------------
// slotted_page_slot_manager_top
// Slot directory of one slotted page: tuple count, free pointer, slot table.
//
//  channel   dir  handshake          payload
//  s_        in   s_tvalid/s_tready  s_tdata  : action, tuple_length, slot_number
//  m_        out  m_tvalid/m_tready  m_tdata  : status .. free_bytes
//  cfg_      in   cfg_we             cfg_wdata: page_number
//
// The accept cycle of a request reads the slot memory; the execute state then
// checks the entry, writes it back and loads the result register.
// The result register holds while m_tready is low; the request then waits in the
// execute state and no new request is taken.
// Reset clears the count, pointers, page number and handshake state; the slot
// memory is never cleared, since only slots written by an insert are used.
// ----------------------------------------------------------------------------
module slotted_page_slot_manager_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // [2:0] action, [15:3] tuple_length, [25:16] slot_number
    input  logic [spsm_pkg::IN_W-1:0]   s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // [2:0] status, [33:3] record_page, [42:34] record_slot,
    // [55:43] tuple_offset, [68:56] tuple_size, [81:69] free_bytes
    output logic [spsm_pkg::OUT_W-1:0]  m_tdata,
    input  logic                        cfg_we,
    input  logic [spsm_pkg::PAGE_W-1:0] cfg_wdata
);
    import spsm_pkg::*;

    state_t            state_reg, state_next;
    request_t          req_reg, req_next;
    logic [PAGE_W-1:0] page_reg;
    logic [8:0]        total_reg, total_next;
    logic [BYTE_W-1:0] fp_reg, fp_next;
    logic [BYTE_W-1:0] ae_reg, ae_next;     // end of the slot array
    result_t           res_reg, res_next;
    logic              mvalid_reg, mvalid_next;

    request_t          s_req;
    slot_entry_t       rd_entry, wr_entry;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;

    logic [BYTE_W-1:0] gap, new_fp;
    logic [BYTE_W:0]   need, end_sum;
    logic              no_space, out_of_range, bad_slot, accept;

    assign s_req    = request_t'(s_tdata);
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = OUT_W'(res_reg);

    spsm_ram #(
        .WIDTH ($bits(slot_entry_t)),
        .DEPTH (SLOT_CAP)
    ) u_slots (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (accept),
        .rd_addr (s_req.slot_number[SLOT_W-1:0]),
        .rd_data (rd_entry)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            page_reg   <= '0;
            total_reg  <= '0;
            fp_reg     <= BYTE_W'(PAGE_BYTES);
            ae_reg     <= BYTE_W'(HEADER_BYTES);
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            total_reg  <= total_next;
            fp_reg     <= fp_next;
            ae_reg     <= ae_next;
            mvalid_reg <= mvalid_next;
            if (cfg_we) begin
                page_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg <= req_next;
        res_reg <= res_next;
    end

    always_comb begin
        gap     = (ae_reg > fp_reg) ? '0 : fp_reg - ae_reg;
        need    = {1'b0, req_reg.tuple_length} + (BYTE_W+1)'(SLOT_BYTES);
        no_space = ({1'b0, gap} < need) || (total_reg >= 9'(SLOT_CAP));
        new_fp  = fp_reg - req_reg.tuple_length;
        end_sum = {1'b0, rd_entry.offset} + {1'b0, rd_entry.size};
        out_of_range = req_reg.slot_number >= IDX_W'(total_reg);
        bad_slot = (rd_entry.size == '0) || rd_entry.deleted
                || (rd_entry.offset < BYTE_W'(HEADER_BYTES))
                || ({1'b0, rd_entry.offset} >= (BYTE_W+1)'(PAGE_BYTES))
                || ({1'b0, rd_entry.size} > (BYTE_W+1)'(PAGE_BYTES))
                || (end_sum > (BYTE_W+1)'(PAGE_BYTES))
                || (rd_entry.offset < ae_reg);
    end

    always_comb begin
        state_next  = state_reg;
        req_next    = req_reg;
        total_next  = total_reg;
        fp_next     = fp_reg;
        ae_next     = ae_reg;
        res_next    = res_reg;
        mvalid_next = mvalid_reg && !m_tready;
        wr_en       = 1'b0;
        wr_addr     = total_reg[SLOT_W-1:0];
        wr_entry    = rd_entry;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    req_next   = s_req;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                // hold the request until the result register is free
                if (!mvalid_reg || m_tready) begin
                    res_next        = '0;
                    res_next.status = STAT_INVALID;
                    case (req_reg.action)
                        ACT_INIT: begin
                            total_next      = '0;
                            fp_next         = BYTE_W'(PAGE_BYTES);
                            ae_next         = BYTE_W'(HEADER_BYTES);
                            res_next.status = STAT_OK;
                        end
                        ACT_INSERT: begin
                            if (no_space) begin
                                res_next.status = STAT_NO_SPACE;
                            end else begin
                                wr_en                 = 1'b1;
                                wr_entry.deleted      = 1'b0;
                                wr_entry.size         = req_reg.tuple_length;
                                wr_entry.offset       = new_fp;
                                fp_next               = new_fp;
                                ae_next               = ae_reg + BYTE_W'(SLOT_BYTES);
                                total_next            = total_reg + 9'd1;
                                res_next.status       = STAT_OK;
                                res_next.record_page  = page_reg;
                                res_next.record_slot  = total_reg;
                                res_next.tuple_offset = new_fp;
                                res_next.tuple_size   = req_reg.tuple_length;
                            end
                        end
                        ACT_READ, ACT_MARK, ACT_UNMARK: begin
                            wr_addr = req_reg.slot_number[SLOT_W-1:0];
                            if (out_of_range) begin
                                res_next.status = STAT_OUT_OF_RANGE;
                            end else if (req_reg.action == ACT_READ) begin
                                if (!bad_slot) begin
                                    res_next.status       = STAT_OK;
                                    res_next.tuple_offset = rd_entry.offset;
                                    res_next.tuple_size   = rd_entry.size;
                                end
                            end else if (req_reg.action == ACT_MARK) begin
                                if (rd_entry.deleted) begin
                                    res_next.status = STAT_DELETED;
                                end else begin
                                    wr_en            = 1'b1;
                                    wr_entry.deleted = 1'b1;
                                    res_next.status  = STAT_OK;
                                end
                            end else begin
                                if (!rd_entry.deleted) begin
                                    res_next.status = STAT_NOT_DELETED;
                                end else begin
                                    wr_en            = 1'b1;
                                    wr_entry.deleted = 1'b0;
                                    res_next.status  = STAT_OK;
                                end
                            end
                        end
                        default: begin
                            res_next.status = STAT_INVALID;
                        end
                    endcase
                    res_next.free_bytes = (ae_next > fp_next) ? '0 : fp_next - ae_next;
                    mvalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/spsm_checker.sv]
// ----------------------------------------------------------------------------
// spsm_checker
// Port-level checks for the slot manager, bound to the top level.
// ----------------------------------------------------------------------------
module spsm_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [spsm_pkg::OUT_W-1:0]  m_tdata
);
    import spsm_pkg::*;

    // a held result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one request in flight: no accept right after an accept
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted during execute");

    // after each accept a result is offered: the new one or an older held one
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> ##1 m_tvalid)
        else $error("no result after request");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("handshake not cleared by reset");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[2:0] != 3'd6 && m_tdata[2:0] != 3'd7)
        else $error("undefined status code");

endmodule

bind slotted_page_slot_manager_top spsm_checker u_spsm_checker (.*);
